### sv/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### sv/ofu_pkg.sv
`default_nettype none
package ofu_pkg;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  // addressing modes
  localparam logic [4:0] MODE_IMP    = 5'd0;
  localparam logic [4:0] MODE_R      = 5'd1;
  localparam logic [4:0] MODE_R_R    = 5'd2;
  localparam logic [4:0] MODE_R_D8   = 5'd3;
  localparam logic [4:0] MODE_R_D16  = 5'd4;
  localparam logic [4:0] MODE_D16    = 5'd5;
  localparam logic [4:0] MODE_MR_R   = 5'd6;
  localparam logic [4:0] MODE_R_MR   = 5'd7;
  localparam logic [4:0] MODE_R_HLI  = 5'd8;
  localparam logic [4:0] MODE_R_HLD  = 5'd9;
  localparam logic [4:0] MODE_HLI_R  = 5'd10;
  localparam logic [4:0] MODE_HLD_R  = 5'd11;
  localparam logic [4:0] MODE_R_A8   = 5'd12;
  localparam logic [4:0] MODE_A8_R   = 5'd13;
  localparam logic [4:0] MODE_HL_SPR = 5'd14;
  localparam logic [4:0] MODE_D8     = 5'd15;
  localparam logic [4:0] MODE_A16_R  = 5'd16;
  localparam logic [4:0] MODE_D16_R  = 5'd17;
  localparam logic [4:0] MODE_MR_D8  = 5'd18;
  localparam logic [4:0] MODE_MR     = 5'd19;
  localparam logic [4:0] MODE_R_A16  = 5'd20;

  // result kinds
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // item actions
  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_IMM8 = 5'b00010,
    PH_LO   = 5'b00100,
    PH_HI   = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        action;
    logic        has_instruction;
    logic [4:0]  mode;
    logic [15:0] primary_value;
    logic [15:0] secondary_value;
    logic        primary_is_c;
    logic        secondary_is_c;
    logic [15:0] hl_value;
    logic [15:0] pc_value;
    logic [7:0]  read_data;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] read_address;
    logic [15:0] operand;
    logic [15:0] store_addr;
    logic        store_en;
    logic [15:0] new_pc;
    logic [15:0] new_hl;
    logic        hl_write;
    logic [1:0]  cycles_added;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  held_mode;
    logic [15:0] held_pc;
    logic [7:0]  low_byte;
    logic [15:0] held_dest;
    logic [15:0] held_source;
  } fetch_state_t;

endpackage
`default_nettype wire

### sv/cpu_operand_fetch_unit.sv
// Operand fetch unit: an accepted input word goes through the input register, then the result
// register, to its result word. Throughput one word per cycle, stalls aside.
// The fetch state advances as each word leaves the input register for the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the fetch state to idle
// with all held values zero.
`default_nettype none
`include "assert_macros.svh"
module cpu_operand_fetch_unit (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_action,
  input  wire         in_has_instruction,
  input  wire  [4:0]  in_mode,
  input  wire  [15:0] in_primary_value,
  input  wire  [15:0] in_secondary_value,
  input  wire         in_primary_is_c,
  input  wire         in_secondary_is_c,
  input  wire  [15:0] in_hl_value,
  input  wire  [15:0] in_pc_value,
  input  wire  [7:0]  in_read_data,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_read_address,
  output logic [15:0] out_operand,
  output logic [15:0] out_store_addr,
  output logic        out_store_en,
  output logic [15:0] out_new_pc,
  output logic [15:0] out_new_hl,
  output logic        out_hl_write,
  output logic [1:0]  out_cycles_added
);

  // input register
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  ofu_pkg::item_t        s1_r;
  ofu_pkg::item_t        in_item;

  // result register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  ofu_pkg::result_t      out_r;

  // fetch state and the decode of the word in the input register
  ofu_pkg::fetch_state_t st_r;
  ofu_pkg::fetch_state_t st_nxt;
  ofu_pkg::result_t      res;

  logic advance;   // result register can take a new word this cycle
  logic s1_load;   // input register takes the incoming word
  logic fire;      // word moves from input register to result register

  assign in_item = '{
    action:          in_action,
    has_instruction: in_has_instruction,
    mode:            in_mode,
    primary_value:   in_primary_value,
    secondary_value: in_secondary_value,
    primary_is_c:    in_primary_is_c,
    secondary_is_c:  in_secondary_is_c,
    hl_value:        in_hl_value,
    pc_value:        in_pc_value,
    read_data:       in_read_data
  };

  assign advance  = ~(out_valid_r & out_stall);
  assign fire     = s1_valid_r & advance;
  // input register is free when empty or when its word moves on this cycle
  assign in_stall = s1_valid_r & ~advance;
  assign s1_load  = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance || !s1_valid_r) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  ofu_decode u_decode (
    .item   (s1_r),
    .st     (st_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: ofu_pkg::PH_IDLE, default: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // state moves only when its word is handed to the result register
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= in_item;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_read_address = out_r.read_address;
  assign out_operand      = out_r.operand;
  assign out_store_addr   = out_r.store_addr;
  assign out_store_en     = out_r.store_en;
  assign out_new_pc       = out_r.new_pc;
  assign out_new_hl       = out_r.new_hl;
  assign out_hl_write     = out_r.hl_write;
  assign out_cycles_added = out_r.cycles_added;

  // input is held off only when both registers are full and the sink stalls
  `ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, s1_valid_r && out_valid_r && out_stall)
  // a read request leaves a fetch pending
  `ASSERT_NEXT(a_req_pending, clk, rst_n, fire && res.kind == ofu_pkg::KIND_READ,
    st_r.phase != ofu_pkg::PH_IDLE)
  // a finished fetch or error returns to idle
  `ASSERT_NEXT(a_done_idle, clk, rst_n,
    fire && (res.kind == ofu_pkg::KIND_DONE || res.kind == ofu_pkg::KIND_UNKNOWN),
    st_r.phase == ofu_pkg::PH_IDLE)

endmodule
`default_nettype wire

### sv/ofu_decode.sv
`default_nettype none
// One item against the held fetch state: result word and next state.
module ofu_decode (
  input  var ofu_pkg::item_t        item,
  input  var ofu_pkg::fetch_state_t st,
  output ofu_pkg::result_t          res,
  output ofu_pkg::fetch_state_t     st_nxt
);

  logic [15:0] word16;
  logic [15:0] pc_p1;
  logic [15:0] pc_p2;
  logic [15:0] sec_addr;
  logic [15:0] pri_addr;

  assign word16   = {item.read_data, st.low_byte};
  assign pc_p1    = st.held_pc + 16'd1;
  assign pc_p2    = st.held_pc + 16'd2;
  assign sec_addr = item.secondary_value | (item.secondary_is_c ? ofu_pkg::HIGH_PAGE : 16'h0000);
  assign pri_addr = item.primary_value | (item.primary_is_c ? ofu_pkg::HIGH_PAGE : 16'h0000);

  always_comb begin
    res    = '0;
    st_nxt = st;
    if (item.action == ofu_pkg::ACT_START) begin
      // a new start always drops whatever fetch was pending
      st_nxt.phase     = ofu_pkg::PH_IDLE;
      st_nxt.held_mode = item.mode;
      st_nxt.held_pc   = item.pc_value;
      res.kind         = ofu_pkg::KIND_DONE;
      res.new_pc       = item.pc_value;
      if (item.has_instruction) begin
        unique case (item.mode) inside
          ofu_pkg::MODE_IMP: begin
          end
          ofu_pkg::MODE_R: begin
            res.operand = item.primary_value;
          end
          ofu_pkg::MODE_R_R: begin
            res.operand = item.secondary_value;
          end
          ofu_pkg::MODE_R_D8, ofu_pkg::MODE_R_A8, ofu_pkg::MODE_HL_SPR,
          ofu_pkg::MODE_D8, ofu_pkg::MODE_A8_R, ofu_pkg::MODE_MR_D8: begin
            res              = '0;
            res.kind         = ofu_pkg::KIND_READ;
            res.read_address = item.pc_value;
            st_nxt.phase     = ofu_pkg::PH_IMM8;
            if (item.mode == ofu_pkg::MODE_A8_R) begin
              st_nxt.held_source = item.secondary_value;
            end
            if (item.mode == ofu_pkg::MODE_MR_D8) begin
              st_nxt.held_dest = item.primary_value;
            end
          end
          ofu_pkg::MODE_R_D16, ofu_pkg::MODE_D16, ofu_pkg::MODE_R_A16,
          ofu_pkg::MODE_A16_R, ofu_pkg::MODE_D16_R: begin
            res              = '0;
            res.kind         = ofu_pkg::KIND_READ;
            res.read_address = item.pc_value;
            st_nxt.phase     = ofu_pkg::PH_LO;
            if (item.mode == ofu_pkg::MODE_A16_R || item.mode == ofu_pkg::MODE_D16_R) begin
              st_nxt.held_source = item.secondary_value;
            end
          end
          ofu_pkg::MODE_MR_R: begin
            res.operand    = item.secondary_value;
            res.store_addr = pri_addr;
            res.store_en   = 1'b1;
          end
          ofu_pkg::MODE_R_MR: begin
            res              = '0;
            res.kind         = ofu_pkg::KIND_READ;
            res.read_address = sec_addr;
            st_nxt.phase     = ofu_pkg::PH_DATA;
          end
          ofu_pkg::MODE_R_HLI, ofu_pkg::MODE_R_HLD: begin
            res              = '0;
            res.kind         = ofu_pkg::KIND_READ;
            res.read_address = item.secondary_value;
            st_nxt.phase     = ofu_pkg::PH_DATA;
            st_nxt.held_dest = (item.mode == ofu_pkg::MODE_R_HLI) ?
                               item.hl_value + 16'd1 : item.hl_value - 16'd1;
          end
          ofu_pkg::MODE_HLI_R, ofu_pkg::MODE_HLD_R: begin
            res.operand    = item.secondary_value;
            res.store_addr = item.primary_value;
            res.store_en   = 1'b1;
            res.hl_write   = 1'b1;
            res.new_hl     = (item.mode == ofu_pkg::MODE_HLI_R) ?
                             item.hl_value + 16'd1 : item.hl_value - 16'd1;
          end
          ofu_pkg::MODE_MR: begin
            res              = '0;
            res.kind         = ofu_pkg::KIND_READ;
            res.read_address = item.primary_value;
            st_nxt.phase     = ofu_pkg::PH_DATA;
            st_nxt.held_dest = item.primary_value;
          end
          default: begin
            res.kind = ofu_pkg::KIND_UNKNOWN;
          end
        endcase
      end
    end else begin
      unique case (st.phase)
        ofu_pkg::PH_IMM8: begin
          st_nxt.phase      = ofu_pkg::PH_IDLE;
          res.kind          = ofu_pkg::KIND_DONE;
          res.new_pc        = pc_p1;
          res.cycles_added  = 2'd1;
          res.operand       = {8'h00, item.read_data};
          if (st.held_mode == ofu_pkg::MODE_R_A8) begin
            res              = '0;
            res.kind         = ofu_pkg::KIND_READ;
            res.read_address = ofu_pkg::HIGH_PAGE | {8'h00, item.read_data};
            st_nxt.phase     = ofu_pkg::PH_DATA;
          end else if (st.held_mode == ofu_pkg::MODE_A8_R) begin
            res.operand    = st.held_source;
            res.store_addr = ofu_pkg::HIGH_PAGE | {8'h00, item.read_data};
            res.store_en   = 1'b1;
          end else if (st.held_mode == ofu_pkg::MODE_MR_D8) begin
            res.store_addr = st.held_dest;
            res.store_en   = 1'b1;
          end
        end
        ofu_pkg::PH_LO: begin
          st_nxt.low_byte  = item.read_data;
          st_nxt.phase     = ofu_pkg::PH_HI;
          res.kind         = ofu_pkg::KIND_READ;
          res.read_address = pc_p1;
        end
        ofu_pkg::PH_HI: begin
          st_nxt.phase     = ofu_pkg::PH_IDLE;
          res.kind         = ofu_pkg::KIND_DONE;
          res.new_pc       = pc_p2;
          res.cycles_added = 2'd2;
          res.operand      = word16;
          if (st.held_mode == ofu_pkg::MODE_R_A16) begin
            res              = '0;
            res.kind         = ofu_pkg::KIND_READ;
            res.read_address = word16;
            st_nxt.phase     = ofu_pkg::PH_DATA;
          end else if (st.held_mode == ofu_pkg::MODE_A16_R ||
                       st.held_mode == ofu_pkg::MODE_D16_R) begin
            res.operand    = st.held_source;
            res.store_addr = word16;
            res.store_en   = 1'b1;
          end
        end
        ofu_pkg::PH_DATA: begin
          st_nxt.phase     = ofu_pkg::PH_IDLE;
          res.kind         = ofu_pkg::KIND_DONE;
          res.operand      = {8'h00, item.read_data};
          res.new_pc       = st.held_pc;
          res.cycles_added = 2'd1;
          if (st.held_mode == ofu_pkg::MODE_R_HLI || st.held_mode == ofu_pkg::MODE_R_HLD) begin
            res.new_hl   = st.held_dest;
            res.hl_write = 1'b1;
          end else if (st.held_mode == ofu_pkg::MODE_MR) begin
            res.store_addr = st.held_dest;
            res.store_en   = 1'b1;
          end else if (st.held_mode == ofu_pkg::MODE_R_A16) begin
            res.new_pc       = pc_p2;
            res.cycles_added = 2'd3;
          end else if (st.held_mode == ofu_pkg::MODE_R_A8) begin
            res.new_pc = pc_p1;
          end
        end
        default: begin
          // response with no fetch pending: state untouched
          res.kind = ofu_pkg::KIND_IGNORED;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
